// ===== hdl/gne_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_pkg: shared types and constants of the grid neighbor expander
// Field widths, queue entry layout, state encodings and direction tables.
// ----------------------------------------------------------------------------
package gne_pkg;

    localparam int CELL_BITS     = 16;
    localparam int HVAL_BITS     = 16;
    localparam int SIDE_BITS     = 9;
    localparam int COST_BITS     = 2;
    localparam int DIR_BITS      = 3;
    localparam int MAP_DEPTH     = 65536;
    localparam int QUEUE_DEPTH   = 2;
    localparam int DIV_STEPS     = CELL_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);
    localparam int CFG_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [DIR_BITS-1:0]     DIR_LAST      = 3'd7;
    localparam logic [DIV_CNT_BITS-1:0] DIV_CNT_LAST  = DIV_CNT_BITS'(DIV_STEPS - 1);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_DIV,
        FRONT_PUSH
    } front_state_t;

    typedef enum logic {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [SIDE_BITS-1:0] grid_width;
        logic [SIDE_BITS-1:0] grid_height;
    } cfg_t;

    typedef struct packed {
        op_t                  op;
        logic [CELL_BITS-1:0] cell_index;
        logic [HVAL_BITS-1:0] height_value;
        logic [SIDE_BITS-1:0] col;
        logic [CELL_BITS-1:0] row;
    } entry_t;

    // Column step per direction: E, SE, S, SW, W, NW, N, NE
    function automatic logic signed [1:0] step_dx(input logic [DIR_BITS-1:0] dir);
        logic signed [1:0] d;
        unique case (dir)
            3'd0, 3'd1, 3'd7: d = 2'sd1;
            3'd2, 3'd6:       d = 2'sd0;
            3'd3, 3'd4, 3'd5: d = -2'sd1;
        endcase
        return d;
    endfunction

    // Row step per direction, rows grow toward south
    function automatic logic signed [1:0] step_dy(input logic [DIR_BITS-1:0] dir);
        logic signed [1:0] d;
        unique case (dir)
            3'd1, 3'd2, 3'd3: d = 2'sd1;
            3'd0, 3'd4:       d = 2'sd0;
            3'd5, 3'd6, 3'd7: d = -2'sd1;
        endcase
        return d;
    endfunction

    // Straight moves cost one, diagonal moves two
    function automatic logic [COST_BITS-1:0] step_cost_of(input logic [DIR_BITS-1:0] dir);
        return dir[0] ? 2'd2 : 2'd1;
    endfunction

endpackage

// ===== hdl/gne_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_if: word channels of the grid neighbor expander
// Command channel (writes and queries) and neighbor result channel.
// ----------------------------------------------------------------------------
interface gne_cmd_if import gne_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [CELL_BITS-1:0]        cell_index;
    logic signed [HVAL_BITS-1:0] height_value;

    modport source (output valid, output opcode, output cell_index, output height_value,
                    input ready);
    modport sink   (input valid, input opcode, input cell_index, input height_value,
                    output ready);
endinterface

interface gne_nbr_if import gne_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CELL_BITS-1:0] neighbour_index;
    logic [COST_BITS-1:0] step_cost;
    logic                 is_open;
    logic [DIR_BITS-1:0]  direction;
    logic                 last;

    modport source (output valid, output neighbour_index, output step_cost, output is_open,
                    output direction, output last, input ready);
    modport sink   (input valid, input neighbour_index, input step_cost, input is_open,
                    input direction, input last, output ready);
endinterface

// ===== hdl/gne_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gne_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/gne_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_front: command intake and index split
// Accepts words, splits a query index into column and row with a
// bit-serial divider (width nonzero) and pushes the classified entry into the queue.
// ----------------------------------------------------------------------------
module gne_front import gne_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    gne_cmd_if.sink       cmd,
    output logic          push_valid,
    input  logic          push_ready,
    output entry_t        push_entry
);

    front_state_t             state_reg, state_next;
    op_t                      op_reg, op_next;
    logic [CELL_BITS-1:0]     index_reg, index_next;
    logic [HVAL_BITS-1:0]     hval_reg, hval_next;
    logic [SIDE_BITS-1:0]     rem_reg, rem_next;
    logic [CELL_BITS-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_BITS-1:0]  cnt_reg, cnt_next;

    logic                     accept;
    logic                     need_div;
    logic [SIDE_BITS:0]       trial;
    logic                     fits;

    assign accept   = cmd.valid && cmd.ready;
    assign need_div = (op_t'(cmd.opcode) == OP_QUERY) && (cfg.grid_width != '0);

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[CELL_BITS-1]};
    assign fits  = trial >= {1'b0, cfg.grid_width};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FRONT_IDLE:
            begin
                if (accept)
                begin
                    state_next = need_div ? FRONT_DIV : FRONT_PUSH;
                end
            end
            FRONT_DIV:
            begin
                if (cnt_reg == DIV_CNT_LAST)
                begin
                    state_next = FRONT_PUSH;
                end
            end
            FRONT_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = FRONT_IDLE;
                end
            end
            default: state_next = FRONT_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.ready  = (state_reg == FRONT_IDLE);
        push_valid = (state_reg == FRONT_PUSH);
    end

    always_comb
    begin
        op_next    = op_reg;
        index_next = index_reg;
        hval_next  = hval_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        if (accept)
        begin
            op_next    = op_t'(cmd.opcode);
            index_next = cmd.cell_index;
            hval_next  = cmd.height_value;
            rem_next   = '0;
            quo_next   = need_div ? cmd.cell_index : '0;
            cnt_next   = '0;
        end
        else if (state_reg == FRONT_DIV)
        begin
            rem_next = fits ? SIDE_BITS'(trial - {1'b0, cfg.grid_width})
                            : trial[SIDE_BITS-1:0];
            quo_next = {quo_reg[CELL_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        push_entry.op           = op_reg;
        push_entry.cell_index   = index_reg;
        push_entry.height_value = hval_reg;
        push_entry.col          = rem_reg;
        push_entry.row          = quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FRONT_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        index_reg <= index_next;
        hval_reg  <= hval_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

endmodule

// ===== hdl/gne_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_queue: short entry queue between front and back
// Keeps command order, so writes and queries reach the map in sequence.
// ----------------------------------------------------------------------------
module gne_queue import gne_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_entry,
    output logic   head_valid,
    output entry_t head,
    input  logic   pop
);

    localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    entry_t                slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  do_push;

    assign push_ready = (count_reg != COUNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hdl/gne_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_back: height map and neighbor expansion
// Stores writes, walks the eight directions of a query through a read
// stage and an output register, one neighbor word per cycle while nbr.ready is high.
// ----------------------------------------------------------------------------
module gne_back import gne_pkg::*; #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    head_valid,
    input  entry_t  head,
    output logic    pop,
    gne_nbr_if.source nbr
);

    logic [DIR_BITS-1:0]    dir_reg, dir_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic [CELL_BITS-1:0]   s1_lin_reg;
    logic                   s1_ingrid_reg;
    logic [DIR_BITS-1:0]    s1_dir_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [CELL_BITS-1:0]   out_index_reg;
    logic                   out_open_reg;
    logic [DIR_BITS-1:0]    out_dir_reg;

    logic                   out_free;
    logic                   do_write;
    logic                   issue;
    logic                   load;
    logic signed [1:0]      dx;
    logic signed [1:0]      dy;
    logic                   x_ok;
    logic                   y_ok;
    logic                   ingrid;
    logic [CELL_BITS-1:0]   row_term;
    logic [CELL_BITS-1:0]   lin;
    logic [HEIGHT_BITS-1:0] wr_data;
    logic [HEIGHT_BITS-1:0] rd_data;
    logic                   open_now;

    assign out_free = !out_valid_reg || nbr.ready;
    assign do_write = head_valid && (head.op == OP_WRITE);
    assign issue    = head_valid && (head.op == OP_QUERY) && (!s1_valid_reg || out_free);
    assign load     = s1_valid_reg && out_free;
    assign pop      = do_write || (issue && (dir_reg == DIR_LAST));

    // neighbor position checks for the current direction
    assign dx = step_dx(dir_reg);
    assign dy = step_dy(dir_reg);

    always_comb
    begin
        unique case (dx)
            2'sd1:   x_ok = ({1'b0, head.col} + 1'b1) < {1'b0, cfg.grid_width};
            -2'sd1:  x_ok = (head.col != '0);
            default: x_ok = 1'b1;
        endcase
        // a row far below the grid must not step north back onto it unless adjacent
        unique case (dy)
            2'sd1:   y_ok = ({1'b0, head.row} + 1'b1) < (CELL_BITS + 1)'(cfg.grid_height);
            -2'sd1:  y_ok = (head.row != '0) && (head.row <= CELL_BITS'(cfg.grid_height));
            default: y_ok = head.row < CELL_BITS'(cfg.grid_height);
        endcase
        unique case (dy)
            2'sd1:   row_term = CELL_BITS'(cfg.grid_width);
            -2'sd1:  row_term = CELL_BITS'(0) - CELL_BITS'(cfg.grid_width);
            default: row_term = '0;
        endcase
    end

    assign ingrid = (cfg.grid_width != '0) && x_ok && y_ok;

    // index = col + row * width, so the neighbor is index + dx + dy * width
    assign lin = head.cell_index + CELL_BITS'(dx) + row_term;

    assign wr_data = HEIGHT_BITS'($signed(head.height_value));

    gne_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk     (clk),
        .wr_en   (do_write),
        .wr_addr (head.cell_index),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (lin),
        .rd_data (rd_data)
    );

    assign open_now = s1_ingrid_reg && (rd_data != {HEIGHT_BITS{1'b1}});

    always_comb
    begin
        dir_next       = issue ? dir_reg + 1'b1 : dir_reg;
        s1_valid_next  = issue ? 1'b1 : (load ? 1'b0 : s1_valid_reg);
        out_valid_next = load ? 1'b1 : (nbr.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dir_reg       <= dir_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_lin_reg    <= lin;
            s1_ingrid_reg <= ingrid;
            s1_dir_reg    <= dir_reg;
        end
        if (load)
        begin
            out_index_reg <= open_now ? s1_lin_reg : '0;
            out_open_reg  <= open_now;
            out_dir_reg   <= s1_dir_reg;
        end
    end

    always_comb
    begin
        nbr.valid           = out_valid_reg;
        nbr.neighbour_index = out_index_reg;
        nbr.step_cost       = step_cost_of(out_dir_reg);
        nbr.is_open         = out_open_reg;
        nbr.direction       = out_dir_reg;
        nbr.last            = (out_dir_reg == DIR_LAST);
    end

endmodule

// ===== hdl/grid_neighbor_expander_top.sv =====
// Write word: accepted in the idle state, pushed into the queue from the push state,
//   stored by the back end; the front end takes no new word until it has pushed.
// Query word: bit-serial division (index by grid width) in the front end, then the
//   neighbor words one per cycle while nbr.ready is high, eight in all.
// The front end takes no new word while it divides or waits for room in the queue.
// Reset (rst_n, async, low): clears control state and both grid sizes; map contents stay.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_neighbor_expander_top: 8-neighbor expansion on a height map
// Holds the grid size registers behind an APB port, and joins the front
// end, the entry queue and the back end with its height map.
// ----------------------------------------------------------------------------
module grid_neighbor_expander_top import gne_pkg::*; #(
    parameter int MAX_SIDE    = 256,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    gne_cmd_if.sink                  cmd,
    gne_nbr_if.source                nbr,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    cfg_t                 cfg_reg, cfg_next;
    logic                 cfg_write;
    reg_index_t           cfg_sel;
    logic [SIDE_BITS-1:0] side_raw;
    logic [SIDE_BITS-1:0] side_clamped;

    logic                 push_valid;
    logic                 push_ready;
    entry_t               push_entry;
    logic                 head_valid;
    entry_t               head;
    logic                 pop;

    // ------------------------------------------------------------------
    // Configuration: two size registers, one word each, no wait states.
    // The low nine data bits are kept; sizes above MAX_SIDE saturate when written.
    // ------------------------------------------------------------------
    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite && pready;
    assign cfg_sel      = reg_index_t'(paddr[2]);
    assign side_raw     = pwdata[SIDE_BITS-1:0];
    assign side_clamped = (side_raw > MAX_SIDE) ? SIDE_BITS'(MAX_SIDE) : side_raw;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_GRID_WIDTH:  cfg_next.grid_width  = side_clamped;
                REG_GRID_HEIGHT: cfg_next.grid_height = side_clamped;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_GRID_WIDTH:  prdata = APB_DATA_BITS'(cfg_reg.grid_width);
            REG_GRID_HEIGHT: prdata = APB_DATA_BITS'(cfg_reg.grid_height);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Front end: take a word, split a query index into column and row.
    // ------------------------------------------------------------------
    gne_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // ------------------------------------------------------------------
    // Queue: hold entries in order so each side can stall on its own.
    // ------------------------------------------------------------------
    gne_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // ------------------------------------------------------------------
    // Back end: store writes, read the map for each of the eight
    // neighbors and drive the result words from an output register.
    // ------------------------------------------------------------------
    gne_back #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .nbr        (nbr)
    );

endmodule

// ===== hdl/gne_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_checker: port-level checks of the neighbor result channel
// Watches the result words over time; bound to the top level.
// ----------------------------------------------------------------------------
module gne_checker import gne_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 nbr_valid,
    input logic                 nbr_ready,
    input logic [CELL_BITS-1:0] neighbour_index,
    input logic [COST_BITS-1:0] step_cost,
    input logic                 is_open,
    input logic [DIR_BITS-1:0]  direction,
    input logic                 last
);

    logic [DIR_BITS-1:0] exp_dir_reg;

    // track the direction the next taken word must carry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_dir_reg <= '0;
        end
        else if (nbr_valid && nbr_ready)
        begin
            exp_dir_reg <= direction + 1'b1;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        nbr_valid && !nbr_ready |=> nbr_valid && $stable(neighbour_index)
            && $stable(is_open) && $stable(direction))
        else $error("result word changed while stalled");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        nbr_valid && nbr_ready |-> direction == exp_dir_reg)
        else $error("neighbor words out of direction order");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        nbr_valid |-> last == (direction == DIR_LAST))
        else $error("last flag does not match the final direction");

    a_closed: assert property (@(posedge clk) disable iff (!rst_n)
        nbr_valid && !is_open |-> neighbour_index == '0)
        else $error("closed neighbor carries an index");

    a_cost: assert property (@(posedge clk) disable iff (!rst_n)
        nbr_valid |-> step_cost == (direction[0] ? 2'd2 : 2'd1))
        else $error("step cost does not match direction");

endmodule

bind grid_neighbor_expander_top gne_checker u_gne_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .nbr_valid       (nbr.valid),
    .nbr_ready       (nbr.ready),
    .neighbour_index (nbr.neighbour_index),
    .step_cost       (nbr.step_cost),
    .is_open         (nbr.is_open),
    .direction       (nbr.direction),
    .last            (nbr.last)
);
